FILE: rtl/mec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mec_pkg
// shared widths, constants, types and helpers of the escape counter
// ----------------------------------------------------------------------------
package mec_pkg;

	// field and register widths
	localparam int PIX_W  = 10;
	localparam int PAN_W  = 16;
	localparam int ZOOM_W = 32;
	localparam int ESC_W  = 7;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;

	// image and arithmetic setup
	localparam int WIDTH_PX  = 1024;
	localparam int HEIGHT_PX = 1024;
	localparam int MAX_ITER  = 64;
	localparam int FRAC_BITS = 28;
	localparam int ZOOM_FRAC = 28;

	localparam int Q_W    = FRAC_BITS + 4;
	localparam int QM_W   = Q_W - 1;
	localparam int CNT_W  = $clog2(MAX_ITER + 2);
	localparam int N_UNIT = MAX_ITER + 1;

	localparam longint unsigned K247 = (64'd2 << FRAC_BITS)
		+ ((64'd47 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam longint unsigned K224 = (64'd2 << FRAC_BITS)
		+ ((64'd24 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam longint unsigned K112 = (64'd1 << FRAC_BITS)
		+ ((64'd12 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam longint unsigned STEP_RE  = K247 / longint'(WIDTH_PX);
	localparam longint unsigned STEP_IM  = K224 / longint'(HEIGHT_PX);
	localparam longint unsigned STEP_MAX = (STEP_RE > STEP_IM) ? STEP_RE : STEP_IM;
	localparam int STEP_W = $clog2(STEP_MAX + 1);

	// view offset datapath
	localparam int N_W   = PAN_W + 1;
	localparam int MAG_W = N_W - 1;
	localparam int M_W   = MAG_W + ZOOM_W;
	localparam int LO_W  = 32;
	localparam int HI_W  = M_W - LO_W;
	localparam int S_W   = M_W + STEP_W;

	localparam logic [Q_W-1:0] ESC_LIM = Q_W'(64'd4 << FRAC_BITS);
	localparam logic [ZOOM_W-1:0] ZOOM_RST = ZOOM_W'(64'h1000_0000);

	typedef logic signed [Q_W-1:0] q_t;
	typedef logic signed [Q_W+1:0] qw_t;

	typedef struct packed {
		logic             run;
		logic [CNT_W-1:0] count;
		q_t               re;
		q_t               im;
		q_t               c_re;
		q_t               c_im;
	} pix_t;

	typedef enum logic [1:0] {
		REG_PAN_X = 2'd0,
		REG_PAN_Y = 2'd1,
		REG_ZOOM  = 2'd2
	} reg_idx_t;

	// clamp a widened value into the q range
	function automatic q_t sat_q(input qw_t v);
		logic fits;
		fits = (v[Q_W+1:Q_W-1] == 3'b000) || (v[Q_W+1:Q_W-1] == 3'b111);
		if (!fits) begin
			return v[Q_W+1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
		end
		return v[Q_W-1:0];
	endfunction

	// per-axis step size: 0 real, 1 imaginary
	function automatic logic [STEP_W-1:0] ax_step(input logic ax);
		return ax ? STEP_W'(STEP_IM) : STEP_W'(STEP_RE);
	endfunction

	// per-axis origin of the plane
	function automatic qw_t ax_base(input logic ax);
		qw_t two;
		two = (Q_W+2)'(64'd2 << FRAC_BITS);
		return ax ? (Q_W+2)'(K112) : -two;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/mec_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mec_map
// five-stage pipeline mapping a pixel to the point c of the complex plane
// ----------------------------------------------------------------------------
module mec_map (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           en,
	input  wire                           in_vld,
	input  wire  [mec_pkg::PIX_W-1:0]     pixel_col,
	input  wire  [mec_pkg::PIX_W-1:0]     pixel_row,
	input  wire  [mec_pkg::PAN_W-1:0]     pan_x,
	input  wire  [mec_pkg::PAN_W-1:0]     pan_y,
	input  wire  [mec_pkg::ZOOM_W-1:0]    zoom_factor,
	output logic                          out_vld,
	output mec_pkg::pix_t                 out_pix
);
	import mec_pkg::*;

	logic [PIX_W-1:0]  pix_ln [2];
	logic [PAN_W-1:0]  pan_ln [2];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic                  neg_s1 [2];
	logic [MAG_W-1:0]      mag_s1 [2];
	logic                  neg_s2 [2];
	logic [M_W-1:0]        m_s2   [2];
	logic                  neg_s3 [2];
	logic [LO_W+STEP_W-1:0] plo_s3 [2];
	logic [HI_W+STEP_W-1:0] phi_s3 [2];
	logic                  neg_s4 [2];
	logic [Q_W:0]          off_s4 [2];
	q_t                    c_s5   [2];

	assign pix_ln[0] = pixel_col;
	assign pix_ln[1] = pixel_row;
	assign pan_ln[0] = pan_x;
	assign pan_ln[1] = pan_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	for (genvar a = 0; a < 2; a++) begin : g_lane
		logic signed [N_W-1:0] n;
		logic [N_W-1:0]        n_u;
		logic [N_W-1:0]        n_mag;
		logic [S_W-1:0]        sum;
		logic [Q_W:0]          off;
		qw_t                   delta;

		always_comb begin
			n = $signed({{(N_W-PIX_W){1'b0}}, pix_ln[a]})
				+ $signed({{(N_W-PAN_W){pan_ln[a][PAN_W-1]}}, pan_ln[a]});
			n_u   = n;
			n_mag = n[N_W-1] ? (~n_u + 1'b1) : n_u;
		end

		// offset magnitude, truncated and limited to the cap
		always_comb begin
			sum = (S_W'(phi_s3[a]) << LO_W) + S_W'(plo_s3[a]);
			if (|sum[S_W-1:ZOOM_FRAC+Q_W]) begin
				off = {1'b1, {Q_W{1'b0}}};
			end else begin
				off = {1'b0, sum[ZOOM_FRAC+Q_W-1:ZOOM_FRAC]};
			end
		end

		// imaginary axis subtracts the offset
		always_comb begin
			delta = $signed({1'b0, off_s4[a]});
			if (neg_s4[a] ^ 1'(a)) begin
				delta = -delta;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s1[a] <= n[N_W-1];
				mag_s1[a] <= n_mag[MAG_W-1:0];
				neg_s2[a] <= neg_s1[a];
				m_s2[a]   <= mag_s1[a] * zoom_factor;
				neg_s3[a] <= neg_s2[a];
				plo_s3[a] <= m_s2[a][LO_W-1:0] * ax_step(1'(a));
				phi_s3[a] <= m_s2[a][M_W-1:LO_W] * ax_step(1'(a));
				neg_s4[a] <= neg_s3[a];
				off_s4[a] <= off;
				c_s5[a]   <= sat_q(ax_base(1'(a)) + delta);
			end
		end
	end

	always_comb begin
		out_vld       = vld_s5;
		out_pix.run   = 1'b1;
		out_pix.count = '0;
		out_pix.re    = '0;
		out_pix.im    = '0;
		out_pix.c_re  = c_s5[0];
		out_pix.c_im  = c_s5[1];
	end

endmodule
`default_nettype wire

FILE: rtl/mec_iter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mec_iter
// one z = z^2 + c iteration: multiply stage, then add, clamp and escape test
// ----------------------------------------------------------------------------
module mec_iter (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 in_vld,
	input  wire mec_pkg::pix_t  in_pix,
	output logic                out_vld,
	output mec_pkg::pix_t       out_pix
);
	import mec_pkg::*;

	function automatic logic [Q_W-1:0] mag_q(input q_t v);
		logic [Q_W-1:0] u;
		u = v;
		return v[Q_W-1] ? (~u + 1'b1) : u;
	endfunction

	// product shifted down to q, saturated at the q maximum
	function automatic logic [QM_W-1:0] mul_sat(input logic [Q_W-1:0] x,
		input logic [Q_W-1:0] y);
		logic [2*Q_W-1:0] p;
		p = x * y;
		if (|p[2*Q_W-1:FRAC_BITS+QM_W]) begin
			return '1;
		end
		return p[FRAC_BITS+QM_W-1:FRAC_BITS];
	endfunction

	logic            vld_s1;
	pix_t            pix_s1;
	logic [QM_W-1:0] sq_re_s1;
	logic [QM_W-1:0] sq_im_s1;
	logic [QM_W-1:0] cross_s1;
	logic            xneg_s1;
	logic            vld_s2;
	pix_t            pix_s2;

	logic [Q_W-1:0]  re_mag;
	logic [Q_W-1:0]  im_mag;
	logic [Q_W-1:0]  sum_sq;
	logic            cont;
	qw_t             twice;
	qw_t             im_w;
	qw_t             re_w;
	pix_t            nxt;

	assign re_mag = mag_q(in_pix.re);
	assign im_mag = mag_q(in_pix.im);

	always_comb begin
		sum_sq = {1'b0, sq_re_s1} + {1'b0, sq_im_s1};
		cont   = pix_s1.run && (sum_sq <= ESC_LIM);
		twice  = $signed({2'b00, cross_s1, 1'b0});
		if (xneg_s1) begin
			twice = -twice;
		end
		im_w = twice + $signed({{2{pix_s1.c_im[Q_W-1]}}, pix_s1.c_im});
		re_w = $signed({3'b000, sq_re_s1}) - $signed({3'b000, sq_im_s1})
			+ $signed({{2{pix_s1.c_re[Q_W-1]}}, pix_s1.c_re});
		nxt = pix_s1;
		if (cont) begin
			nxt.re    = sat_q(re_w);
			nxt.im    = sat_q(im_w);
			nxt.count = pix_s1.count + 1'b1;
		end else begin
			nxt.run = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1   <= in_pix;
			sq_re_s1 <= mul_sat(re_mag, re_mag);
			sq_im_s1 <= mul_sat(im_mag, im_mag);
			cross_s1 <= mul_sat(re_mag, im_mag);
			xneg_s1  <= in_pix.re[Q_W-1] ^ in_pix.im[Q_W-1];
			pix_s2   <= nxt;
		end
	end

	assign out_vld = vld_s2;
	assign out_pix = pix_s2;

endmodule
`default_nettype wire

FILE: rtl/mec_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mec_outq
// two-entry result queue; the pipeline advances while the second slot is free
// ----------------------------------------------------------------------------
module mec_outq (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_vld,
	input  wire  [mec_pkg::ESC_W-1:0]  in_cnt,
	output logic                       accept_en,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [mec_pkg::ESC_W-1:0]  out_cnt
);
	import mec_pkg::*;

	logic             v0_q;
	logic             v1_q;
	logic [ESC_W-1:0] d0_q;
	logic [ESC_W-1:0] d1_q;
	logic             push;
	logic             pop;

	assign accept_en = !v1_q;
	assign push      = in_vld && accept_en;
	assign pop       = out_ready && v0_q;
	assign out_valid = v0_q;
	assign out_cnt   = d0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			unique case ({push, pop})
				2'b10: begin
					v0_q <= 1'b1;
					v1_q <= v0_q;
				end
				2'b01: begin
					v0_q <= v1_q;
					v1_q <= 1'b0;
				end
				default: begin
					v0_q <= v0_q;
					v1_q <= v1_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (v0_q) begin
					d1_q <= in_cnt;
				end else begin
					d0_q <= in_cnt;
				end
			end
			2'b01: begin
				d0_q <= d1_q;
			end
			2'b11: begin
				if (v1_q) begin
					d0_q <= d1_q;
					d1_q <= in_cnt;
				end else begin
					d0_q <= in_cnt;
				end
			end
			default: begin
				d0_q <= d0_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q)
		else $error("result queue second slot held without head");
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> v0_q)
		else $error("result queue lost a pushed request");
	a_pop_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && v1_q) |=> (v0_q && (d0_q == $past(d1_q))))
		else $error("result queue did not move second slot to head");
`endif

endmodule
`default_nettype wire

FILE: rtl/mandelbrot_escape_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter
// escape-time count of one pixel, fully unrolled iteration pipeline
//
//   channel   handshake                 payload
//   pixel     pix_valid / pix_ready     pixel_col, pixel_row
//   count     cnt_valid / cnt_ready     escape_count
//   config    apb write / read          pan_x, pan_y, zoom_factor
//
// one pixel per cycle while the result queue has room; the pipeline is 5 mapping
// stages plus 2 stages for each of the 65 iteration units, then the result queue
// every pixel runs through all iteration units; escaped pixels just hold
// reset clears all valid bits and loads pan 0, zoom 1.0
// the pipeline freezes while the two-entry result queue is full; pix_ready
// comes from a register
// ----------------------------------------------------------------------------
module mandelbrot_escape_counter (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          pix_valid,
	output logic                         pix_ready,
	input  wire  [mec_pkg::PIX_W-1:0]    pixel_col,
	input  wire  [mec_pkg::PIX_W-1:0]    pixel_row,
	output logic                         cnt_valid,
	input  wire                          cnt_ready,
	output logic [mec_pkg::ESC_W-1:0]    escape_count,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [mec_pkg::ADDR_W-1:0]   paddr,
	input  wire  [mec_pkg::DATA_W-1:0]   pwdata,
	output logic [mec_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import mec_pkg::*;

	logic [PAN_W-1:0]  pan_x_q;
	logic [PAN_W-1:0]  pan_y_q;
	logic [ZOOM_W-1:0] zoom_q;
	reg_idx_t          reg_idx;
	logic              wr_en;
	logic              en;

	logic vld_chain [N_UNIT+1];
	pix_t pix_chain [N_UNIT+1];

	// config registers
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_x_q <= '0;
			pan_y_q <= '0;
			zoom_q  <= ZOOM_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PAN_X: pan_x_q <= pwdata[PAN_W-1:0];
				REG_PAN_Y: pan_y_q <= pwdata[PAN_W-1:0];
				REG_ZOOM:  zoom_q  <= pwdata[ZOOM_W-1:0];
				default: begin
					zoom_q <= zoom_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PAN_X: prdata = {{(DATA_W-PAN_W){pan_x_q[PAN_W-1]}}, pan_x_q};
			REG_PAN_Y: prdata = {{(DATA_W-PAN_W){pan_y_q[PAN_W-1]}}, pan_y_q};
			REG_ZOOM:  prdata = DATA_W'(zoom_q);
			default:   prdata = '0;
		endcase
	end

	assign pix_ready = en;

	mec_map u_map (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (pix_valid),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.pan_x       (pan_x_q),
		.pan_y       (pan_y_q),
		.zoom_factor (zoom_q),
		.out_vld     (vld_chain[0]),
		.out_pix     (pix_chain[0])
	);

	for (genvar k = 0; k < N_UNIT; k++) begin : g_iter
		mec_iter u_iter (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (vld_chain[k]),
			.in_pix  (pix_chain[k]),
			.out_vld (vld_chain[k+1]),
			.out_pix (pix_chain[k+1])
		);
	end

	mec_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_chain[N_UNIT]),
		.in_cnt    (ESC_W'(pix_chain[N_UNIT].count)),
		.accept_en (en),
		.out_valid (cnt_valid),
		.out_ready (cnt_ready),
		.out_cnt   (escape_count)
	);

endmodule
`default_nettype wire
